>>> hw/rtl/rrms_pkg.sv
`timescale 1ns / 1ps
// Package for the register rename map and ready scoreboard.
// Field widths, stream packing, action and config codes, reset-value helpers.
// No dependencies.
package rrms_pkg;

    // fixed field widths
    localparam int ACTION_W = 3;
    localparam int ARCH_W   = 7;
    localparam int PHYS_W   = 8;
    localparam int FINT_W   = 6;
    localparam int FFLT_W   = 8;
    localparam int ZERO_W   = 7;

    // input stream packing: action in tuser, rest in tdata
    localparam int S_ARCH_LSB  = 0;
    localparam int S_PHYS_LSB  = S_ARCH_LSB + ARCH_W;
    localparam int S_FINT_LSB  = S_PHYS_LSB + PHYS_W;
    localparam int S_FFLT_LSB  = S_FINT_LSB + FINT_W;
    localparam int S_USED_W    = S_FFLT_LSB + FFLT_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // output stream packing: bad_request in tuser, rest in tdata
    localparam int M_USED_W    = 2 * PHYS_W + 3;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_USED_W;

    // config port
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_ZERO   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_ZERO = 1'b1;
    localparam logic [ZERO_W-1:0]    RST_INT_ZERO   = 7'd31;
    localparam logic [ZERO_W-1:0]    RST_FLOAT_ZERO = 7'd63;

    // default geometry
    localparam int DEF_NUM_LOG_INT    = 32;
    localparam int DEF_NUM_PHYS_INT   = 64;
    localparam int DEF_NUM_LOG_FLOAT  = 32;
    localparam int DEF_NUM_PHYS_FLOAT = 64;
    localparam int DEF_NUM_MISC       = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RENAME = 3'd0,
        ACT_LOOKUP = 3'd1,
        ACT_QUERY  = 3'd2,
        ACT_SET    = 3'd3,
        ACT_MARK   = 3'd4
    } action_t;

    // map entry after reset: identity for int, offset into float bank for float
    function automatic logic [PHYS_W-1:0] map_reset_val(
        input int idx, input int n_log_int, input int n_phys_int);
        if (idx < n_log_int) begin
            return PHYS_W'(idx);
        end
        return PHYS_W'(n_phys_int + idx - n_log_int);
    endfunction

    // scoreboard bit after reset
    function automatic logic ready_reset_val(
        input int idx, input int n_log_int, input int n_phys_int,
        input int n_log_float, input int n_phys_float);
        return (idx < n_log_int) ||
               ((idx >= n_phys_int) && (idx < n_phys_int + n_log_float)) ||
               (idx >= n_phys_int + n_phys_float);
    endfunction

endpackage

>>> hw/rtl/register_rename_map_scoreboard.sv
`timescale 1ns / 1ps
// Register rename map with ready scoreboard, top level.
// Uses rrms_pkg for field packing, action codes and reset values.
//
//  channel   dir  handshake           tdata (low bit up)                 tuser
//  s_        in   s_tvalid/s_tready   arch index, phys index,            action
//                                     free int reg, free float reg, pad
//  m_        out  m_tvalid/m_tready   mapped_reg, prev_mapped_reg,       bad_request
//                                     is_ready, took_int_free,
//                                     took_float_free, zero pad
//  cfg_      in   cfg_wr_en           cfg_addr selects register, cfg_wdata
//
// On accept the block issues the synchronous reads of the map and scoreboard
// memories; then, in exec, it writes back and loads the output register.
// A new item is not taken while one is in exec, since the memory reads are
// registered.
// Reset clears per-entry valid flags; an entry not yet written reads as its
// reset value, so there is no clearing pass. A held result blocks the next item.
module register_rename_map_scoreboard #(
    parameter int NUM_LOG_INT    = rrms_pkg::DEF_NUM_LOG_INT,
    parameter int NUM_PHYS_INT   = rrms_pkg::DEF_NUM_PHYS_INT,
    parameter int NUM_LOG_FLOAT  = rrms_pkg::DEF_NUM_LOG_FLOAT,
    parameter int NUM_PHYS_FLOAT = rrms_pkg::DEF_NUM_PHYS_FLOAT,
    parameter int NUM_MISC       = rrms_pkg::DEF_NUM_MISC
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rrms_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [rrms_pkg::ZERO_W-1:0]       cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // arch index, phys index, free int reg, free float reg, pad
    input  logic [rrms_pkg::S_TDATA_W-1:0]    s_tdata,
    // action
    input  logic [rrms_pkg::ACTION_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // mapped_reg, prev_mapped_reg, is_ready, took_int_free, took_float_free, pad
    output logic [rrms_pkg::M_TDATA_W-1:0]    m_tdata,
    // bad_request
    output logic [0:0]                        m_tuser
);
    import rrms_pkg::*;

    localparam int LOG_TOTAL   = NUM_LOG_INT + NUM_LOG_FLOAT;
    localparam int PHYS_TOTAL  = NUM_PHYS_INT + NUM_PHYS_FLOAT;
    localparam int READY_DEPTH = PHYS_TOTAL + NUM_MISC;
    localparam int MAP_AW      = $clog2(LOG_TOTAL);
    localparam int RDY_AW      = $clog2(READY_DEPTH);

    // config registers
    logic [ZERO_W-1:0] int_zero_reg;
    logic [ZERO_W-1:0] float_zero_reg;

    // control
    logic busy_reg;
    logic m_tvalid_reg;
    logic accept;

    // accepted item
    logic [ACTION_W-1:0] in_act_reg;
    logic [ARCH_W-1:0]   in_aidx_reg;
    logic [PHYS_W-1:0]   in_pidx_reg;
    logic [FINT_W-1:0]   in_fint_reg;
    logic [FFLT_W-1:0]   in_fflt_reg;

    // input fields
    logic [ARCH_W-1:0] s_arch;
    logic [PHYS_W-1:0] s_phys;

    // memories and their valid flags
    logic [PHYS_W-1:0]      map_mem [LOG_TOTAL];
    logic                   ready_mem [READY_DEPTH];
    logic [LOG_TOTAL-1:0]   map_vld_reg;
    logic [READY_DEPTH-1:0] rdy_vld_reg;

    logic [MAP_AW-1:0] map_raddr;
    logic [RDY_AW-1:0] rdy_raddr;
    logic [PHYS_W-1:0] map_rd_reg;
    logic              map_rd_vld_reg;
    logic              rdy_rd_reg;
    logic              rdy_rd_vld_reg;

    logic [PHYS_W-1:0] map_cur;
    logic              rdy_cur;

    // write-back
    logic              map_we;
    logic [MAP_AW-1:0] map_waddr;
    logic [PHYS_W-1:0] map_wdata;
    logic              rdy_we;
    logic [RDY_AW-1:0] rdy_waddr;
    logic              rdy_wdata;

    // decode of the held item
    logic              is_int;
    logic              is_flt;
    logic              is_misc;
    logic              fint_ok;
    logic              fflt_ok;
    logic              phys_in_bank;
    logic              phys_in_rdy;
    logic [RDY_AW-1:0] slot_idx;
    logic [PHYS_W-1:0] slot_val;

    // result
    logic [PHYS_W-1:0] res_mapped;
    logic [PHYS_W-1:0] res_prev;
    logic              res_rdy;
    logic              res_tint;
    logic              res_tflt;
    logic              res_bad;

    logic [PHYS_W-1:0] m_mapped_reg;
    logic [PHYS_W-1:0] m_prev_reg;
    logic              m_rdy_reg;
    logic              m_tint_reg;
    logic              m_tflt_reg;
    logic              m_bad_reg;

    assign s_arch = s_tdata[S_ARCH_LSB +: ARCH_W];
    assign s_phys = s_tdata[S_PHYS_LSB +: PHYS_W];

    // one item in flight; output slot must be free or emptying
    assign s_tready = !busy_reg && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign map_raddr = (int'(s_arch) < LOG_TOTAL)   ? MAP_AW'(s_arch) : '0;
    assign rdy_raddr = (int'(s_phys) < READY_DEPTH) ? RDY_AW'(s_phys) : '0;

    // --- config writes ---
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_zero_reg   <= RST_INT_ZERO;
            float_zero_reg <= RST_FLOAT_ZERO;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_INT_ZERO:   int_zero_reg   <= cfg_wdata;
                CFG_FLOAT_ZERO: float_zero_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // --- control ---
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg <= accept;
            if (busy_reg) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // --- item capture ---
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_act_reg  <= s_tuser;
            in_aidx_reg <= s_arch;
            in_pidx_reg <= s_phys;
            in_fint_reg <= s_tdata[S_FINT_LSB +: FINT_W];
            in_fflt_reg <= s_tdata[S_FFLT_LSB +: FFLT_W];
        end
    end

    // --- memories: read on accept, write back in the exec cycle ---
    always_ff @(posedge aclk) begin
        if (accept) begin
            map_rd_reg     <= map_mem[map_raddr];
            rdy_rd_reg     <= ready_mem[rdy_raddr];
            map_rd_vld_reg <= map_vld_reg[map_raddr];
            rdy_rd_vld_reg <= rdy_vld_reg[rdy_raddr];
        end
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (rdy_we) begin
            ready_mem[rdy_waddr] <= rdy_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_vld_reg <= '0;
            rdy_vld_reg <= '0;
        end else begin
            if (map_we) begin
                map_vld_reg[map_waddr] <= 1'b1;
            end
            if (rdy_we) begin
                rdy_vld_reg[rdy_waddr] <= 1'b1;
            end
        end
    end

    // unwritten entries read as their reset value
    assign map_cur = map_rd_vld_reg ? map_rd_reg
                   : map_reset_val(int'(in_aidx_reg), NUM_LOG_INT, NUM_PHYS_INT);
    assign rdy_cur = rdy_rd_vld_reg ? rdy_rd_reg
                   : ready_reset_val(int'(in_pidx_reg), NUM_LOG_INT, NUM_PHYS_INT,
                                     NUM_LOG_FLOAT, NUM_PHYS_FLOAT);

    // --- decode ---
    assign is_int  = int'(in_aidx_reg) < NUM_LOG_INT;
    assign is_flt  = !is_int && (int'(in_aidx_reg) < LOG_TOTAL);
    assign is_misc = (int'(in_aidx_reg) >= LOG_TOTAL) &&
                     (int'(in_aidx_reg) < LOG_TOTAL + NUM_MISC);
    assign fint_ok = (int'(in_fint_reg) < NUM_PHYS_INT) &&
                     (int'(in_fint_reg) < READY_DEPTH);
    assign fflt_ok = (int'(in_fflt_reg) >= NUM_PHYS_INT) &&
                     (int'(in_fflt_reg) < PHYS_TOTAL);
    assign phys_in_bank = int'(in_pidx_reg) < PHYS_TOTAL;
    assign phys_in_rdy  = int'(in_pidx_reg) < READY_DEPTH;
    // fixed scoreboard slot of a misc register
    assign slot_idx = RDY_AW'(PHYS_TOTAL - LOG_TOTAL + int'(in_aidx_reg));
    assign slot_val = PHYS_W'(PHYS_TOTAL - LOG_TOTAL + int'(in_aidx_reg));

    // --- execute ---
    always_comb begin
        res_mapped = '0;
        res_prev   = '0;
        res_rdy    = 1'b0;
        res_tint   = 1'b0;
        res_tflt   = 1'b0;
        res_bad    = 1'b0;
        map_we     = 1'b0;
        map_waddr  = is_int || is_flt ? MAP_AW'(in_aidx_reg) : '0;
        map_wdata  = '0;
        rdy_we     = 1'b0;
        rdy_waddr  = '0;
        rdy_wdata  = 1'b0;
        if (busy_reg) begin
            unique case (action_t'(in_act_reg))
                ACT_RENAME: begin
                    if (is_int) begin
                        if (in_aidx_reg == int_zero_reg) begin
                            // zero register: report only
                            res_mapped = PHYS_W'(int_zero_reg);
                            res_prev   = map_cur;
                        end else if (fint_ok) begin
                            res_prev   = map_cur;
                            res_mapped = PHYS_W'(in_fint_reg);
                            res_tint   = 1'b1;
                            map_we     = 1'b1;
                            map_wdata  = PHYS_W'(in_fint_reg);
                            rdy_we     = 1'b1;
                            rdy_waddr  = RDY_AW'(in_fint_reg);
                        end else begin
                            res_bad = 1'b1;
                        end
                    end else if (is_flt) begin
                        if (in_aidx_reg == float_zero_reg) begin
                            res_mapped = PHYS_W'(float_zero_reg);
                            res_prev   = map_cur;
                        end else if (fflt_ok) begin
                            res_prev   = map_cur;
                            res_mapped = in_fflt_reg;
                            res_tflt   = 1'b1;
                            map_we     = 1'b1;
                            map_wdata  = in_fflt_reg;
                            rdy_we     = 1'b1;
                            rdy_waddr  = RDY_AW'(in_fflt_reg);
                        end else begin
                            res_bad = 1'b1;
                        end
                    end else if (is_misc) begin
                        res_mapped = slot_val;
                        res_prev   = slot_val;
                        rdy_we     = 1'b1;
                        rdy_waddr  = slot_idx;
                    end else begin
                        res_bad = 1'b1;
                    end
                end
                ACT_LOOKUP: begin
                    if (is_int || is_flt) begin
                        res_mapped = map_cur;
                    end else if (is_misc) begin
                        res_mapped = slot_val;
                    end else begin
                        res_bad = 1'b1;
                    end
                end
                ACT_QUERY: begin
                    if (phys_in_rdy) begin
                        res_rdy = rdy_cur;
                    end else begin
                        res_bad = 1'b1;
                    end
                end
                ACT_SET: begin
                    if ((is_int || is_flt) && phys_in_bank) begin
                        map_we    = 1'b1;
                        map_wdata = in_pidx_reg;
                    end else begin
                        res_bad = 1'b1;
                    end
                end
                ACT_MARK: begin
                    if (phys_in_rdy) begin
                        rdy_we    = 1'b1;
                        rdy_waddr = RDY_AW'(in_pidx_reg);
                        rdy_wdata = 1'b1;
                    end else begin
                        res_bad = 1'b1;
                    end
                end
                default: res_bad = 1'b1;
            endcase
        end
    end

    // --- output register ---
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            m_mapped_reg <= res_mapped;
            m_prev_reg   <= res_prev;
            m_rdy_reg    <= res_rdy;
            m_tint_reg   <= res_tint;
            m_tflt_reg   <= res_tflt;
            m_bad_reg    <= res_bad;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_tflt_reg, m_tint_reg, m_rdy_reg,
                       m_prev_reg, m_mapped_reg};
    assign m_tuser  = m_bad_reg;

`ifndef SYNTHESIS
    // an accepted item is always in exec on the next cycle
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> busy_reg)
        else $error("accepted item did not enter exec");

    // exec always delivers a result, and exec has ended by the next cycle
    a_exec_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |=> (m_tvalid && !busy_reg))
        else $error("exec did not produce a result");

    // a rejected request never reports a consumed free register
    a_bad_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (!m_tint_reg && !m_tflt_reg))
        else $error("bad request with free register taken");

    // no write-back outside exec
    a_write_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (map_we || rdy_we) |-> busy_reg)
        else $error("memory write outside exec");
`endif

endmodule
